// ===== sv/yrl_pkg.sv =====
// ---------------------------------------------------------------------------
// Yaw rate limiter package
// Shared types, constants and helper functions of the yaw rate limiter.
// ---------------------------------------------------------------------------
`default_nettype none

package yrl_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   // Configuration register indexes and reset values
   localparam logic [0:0]  CSR_MAX_RATE = 1'b0;
   localparam logic [0:0]  CSR_MIN_DIST = 1'b1;
   localparam logic [14:0] MAX_RATE_RST = 15'd25736;
   localparam logic [30:0] MIN_DIST_RST = 31'd6554;

   // Mode codes on the request side
   localparam logic [1:0] MODE_TRACK = 2'd0;
   localparam logic [1:0] MODE_HOLD  = 2'd1;

   localparam int ANG_W        = 18;
   localparam int CORD_W       = 36;
   localparam int Z_W          = 22;
   localparam int CORDIC_STEPS = 17;
   localparam int DIV_N_W      = 36;
   localparam int DIV_D_W      = 20;
   localparam int MC_W         = 16;

   localparam logic signed [ANG_W-1:0] PI_Q13     = 18'sd25736;
   localparam logic signed [ANG_W-1:0] TWO_PI_Q13 = 18'sd51472;
   localparam logic signed [Z_W-1:0]   PI_Q16     = 22'sd205887;
   localparam logic [DIV_D_W-1:0]      USEC_PER_S = 20'd1000000;
   localparam logic [DIV_N_W-1:0]      HALF_SEC   = 36'd500000;
   localparam logic signed [15:0]      RATE_MAX   = 16'sd32767;
   localparam logic signed [15:0]      RATE_MIN   = -16'sd32768;

   typedef enum logic [1:0] {
      KIND_TRACK = 2'd0,
      KIND_HOLD  = 2'd1,
      KIND_VOID  = 2'd2
   } kind_type;

   // One classified tick passed from the front to the back
   typedef struct packed {
      kind_type              kind;
      logic                  far;
      logic signed [31:0]    dir_x;
      logic signed [31:0]    dir_y;
      logic [19:0]           elapsed_us;
      logic [MC_W-1:0]       step_max;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   // Arctangent of 2^-i in Q16 radians, first entry is pi/4
   function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
      case (i)
         5'd0:    atan_q16 = 22'sd51472;
         5'd1:    atan_q16 = 22'sd30386;
         5'd2:    atan_q16 = 22'sd16055;
         5'd3:    atan_q16 = 22'sd8150;
         5'd4:    atan_q16 = 22'sd4091;
         5'd5:    atan_q16 = 22'sd2047;
         5'd6:    atan_q16 = 22'sd1024;
         5'd7:    atan_q16 = 22'sd512;
         5'd8:    atan_q16 = 22'sd256;
         5'd9:    atan_q16 = 22'sd128;
         5'd10:   atan_q16 = 22'sd64;
         5'd11:   atan_q16 = 22'sd32;
         5'd12:   atan_q16 = 22'sd16;
         5'd13:   atan_q16 = 22'sd8;
         5'd14:   atan_q16 = 22'sd4;
         5'd15:   atan_q16 = 22'sd2;
         5'd16:   atan_q16 = 22'sd1;
         default: atan_q16 = 22'sd0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== sv/yrl_div.sv =====
// ---------------------------------------------------------------------------
// Yaw rate limiter divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module yrl_div import yrl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_N_W-1:0] dividend,
   input  wire logic [DIV_D_W-1:0] divisor,
   output logic                    done,
   output logic [DIV_N_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIV_N_W + 1);

   logic [DIV_N_W-1:0] quo_ff, quo_in;
   logic [DIV_D_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in, done_ff, done_in;
   logic [DIV_D_W:0]   trial;
   logic               fits;

   assign trial = {rem_ff, quo_ff[DIV_N_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = CNT_W'(DIV_N_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? DIV_D_W'(trial - {1'b0, div_ff}) : DIV_D_W'(trial);
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== sv/yrl_front.sv =====
// ---------------------------------------------------------------------------
// Yaw rate limiter front end
// Accepts ticks, tests the look-ahead length and works out the step limit.
// ---------------------------------------------------------------------------
`default_nettype none

module yrl_front import yrl_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_mode,
   input  wire logic [31:0]  req_dir_x,
   input  wire logic [31:0]  req_dir_y,
   input  wire logic [19:0]  req_elapsed_us,
   input  wire logic [14:0]  max_rate,
   input  wire logic [30:0]  min_dist,
   input  wire logic         q_full,
   output logic              q_push,
   output item_type          q_item
);

   typedef enum logic [6:0] {
      F_IDLE = 7'b0000001,
      F_SQX  = 7'b0000010,
      F_SQY  = 7'b0000100,
      F_SQM  = 7'b0001000,
      F_MUL  = 7'b0010000,
      F_DIV  = 7'b0100000,
      F_PUSH = 7'b1000000
   } fstate_type;

   // Division by one million is a shift by six followed by a multiplication
   // with the rounded-up reciprocal of 15625, scaled by 2^43.
   localparam logic [31:0] STEP_RECIP = 32'd562949954;

   fstate_type         state_ff, state_in;
   item_type           item_ff, item_in;
   logic [63:0]        len_ff, len_in, md2_ff, md2_in;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod;

   assign prod = {32'b0, mul_a} * {32'b0, mul_b};

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      len_in    = len_ff;
      md2_in    = md2_ff;
      mul_a     = mag32(item_ff.dir_x);
      mul_b     = mag32(item_ff.dir_x);
      q_push    = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               case (req_mode)
                  MODE_TRACK: item_in.kind = KIND_TRACK;
                  MODE_HOLD:  item_in.kind = KIND_HOLD;
                  default:    item_in.kind = KIND_VOID;
               endcase
               item_in.dir_x = $signed(req_dir_x);
               item_in.dir_y = $signed(req_dir_y);
               // Zero elapsed time counts as one microsecond.
               item_in.elapsed_us = (req_elapsed_us == 20'd0) ? 20'd1 : req_elapsed_us;
               state_in = F_SQX;
            end
         end
         F_SQX: begin
            len_in   = prod;
            state_in = F_SQY;
         end
         F_SQY: begin
            mul_a    = mag32(item_ff.dir_y);
            mul_b    = mag32(item_ff.dir_y);
            len_in   = len_ff + prod;
            state_in = F_SQM;
         end
         F_SQM: begin
            mul_a    = {1'b0, min_dist};
            mul_b    = {1'b0, min_dist};
            md2_in   = prod;
            state_in = F_MUL;
         end
         F_MUL: begin
            item_in.far = len_ff > md2_ff;
            mul_a       = 32'(max_rate);
            mul_b       = 32'(item_ff.elapsed_us);
            len_in      = prod + 64'(HALF_SEC);
            state_in    = F_DIV;
         end
         F_DIV: begin
            mul_a            = 32'(len_ff[34:6]);
            mul_b            = STEP_RECIP;
            item_in.step_max = prod[58:43];
            state_in         = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      len_ff  <= len_in;
      md2_ff  <= md2_in;
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == F_IDLE);
   assign q_item     = item_ff;

endmodule

`default_nettype wire

// ===== sv/yrl_queue.sv =====
// ---------------------------------------------------------------------------
// Yaw rate limiter queue
// Short first-in first-out queue of classified ticks.
// ---------------------------------------------------------------------------
`default_nettype none

module yrl_queue import yrl_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output item_type      head_item,
   output queue_stat_type stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign head_item  = mem_ff[rd_ff];
   assign stat.full  = (cnt_ff == CW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

`default_nettype wire

// ===== sv/yrl_back.sv =====
// ---------------------------------------------------------------------------
// Yaw rate limiter back end
// Heading by CORDIC, step limiting with wrap, rate division and smoothing.
// ---------------------------------------------------------------------------
`default_nettype none

module yrl_back import yrl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [14:0] max_rate,
   input  wire item_type    q_item,
   input  wire logic        q_empty,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_yaw,
   output logic [15:0]      rsp_rate
);

   typedef enum logic [7:0] {
      B_IDLE = 8'b00000001,
      B_PRE  = 8'b00000010,
      B_NORM = 8'b00000100,
      B_CORD = 8'b00001000,
      B_HEAD = 8'b00010000,
      B_LIM  = 8'b00100000,
      B_DIV  = 8'b01000000,
      B_FIN  = 8'b10000000
   } bstate_type;

   localparam logic signed [CORD_W-1:0] NORM_LIM = CORD_W'(64'sd1 << 30);

   bstate_type                 state_ff, state_in;
   item_type                   cur_ff, cur_in;
   logic signed [CORD_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]      z_ff, z_in;
   logic [4:0]                 i_ff, i_in;
   logic signed [ANG_W-1:0]    tgt_ff, tgt_in, yaw_ff, yaw_in;
   logic signed [15:0]         rate_ff, rate_in;
   logic                       neg_ff, neg_in;
   logic signed [15:0]         last_yaw_ff, last_yaw_in, last_rate_ff, last_rate_in;
   logic                       ov_ff, ov_in;
   logic [15:0]                oy_ff, oy_in, or_ff, or_in;

   logic signed [CORD_W-1:0]   sx, sy, ax, ay;
   logic signed [Z_W-1:0]      zr;
   logic signed [ANG_W-1:0]    last, mc, maxr, d, ch;
   logic [16:0]                dmag;
   logic                       div_start, div_done;
   logic [DIV_N_W-1:0]         div_num, div_quo;
   logic                       out_free;

   assign last = ANG_W'(last_yaw_ff);
   assign mc   = $signed({2'b00, cur_ff.step_max});
   assign maxr = $signed({3'b000, max_rate});
   assign d    = tgt_ff - last;
   assign dmag = d[ANG_W-1] ? 17'(-d) : 17'(d);
   assign sx   = x_ff >>> i_ff;
   assign sy   = y_ff >>> i_ff;
   assign ax   = x_ff;
   assign ay   = y_ff[CORD_W-1] ? -y_ff : y_ff;
   assign zr   = (z_ff + Z_W'(4)) >>> 3;
   assign ch   = (yaw_ff - last < 0) ? last - yaw_ff : yaw_ff - last;
   assign div_num = 36'(37'(dmag) * 37'(USEC_PER_S)) + 36'(cur_ff.elapsed_us >> 1);
   assign out_free = !ov_ff || rsp_tready;

   yrl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (cur_ff.elapsed_us),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      i_in         = i_ff;
      tgt_in       = tgt_ff;
      yaw_in       = yaw_ff;
      rate_in      = rate_ff;
      neg_in       = neg_ff;
      last_yaw_in  = last_yaw_ff;
      last_rate_in = last_rate_ff;
      ov_in        = ov_ff && !rsp_tready;
      oy_in        = oy_ff;
      or_in        = or_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               tgt_in = last;
               if (q_item.kind != KIND_TRACK) begin
                  state_in = B_FIN;
               end else if (q_item.far) begin
                  state_in = B_PRE;
               end else begin
                  state_in = B_LIM;
               end
            end
         end
         B_PRE: begin
            x_in = CORD_W'(cur_ff.dir_x);
            y_in = CORD_W'(cur_ff.dir_y);
            z_in = '0;
            // A vector pointing backwards is turned half a circle first.
            if (cur_ff.dir_x < 0) begin
               x_in = -CORD_W'(cur_ff.dir_x);
               y_in = -CORD_W'(cur_ff.dir_y);
               z_in = (cur_ff.dir_y >= 0) ? PI_Q16 : -PI_Q16;
            end
            state_in = B_NORM;
         end
         B_NORM: begin
            if (ax < NORM_LIM && ay < NORM_LIM) begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end else begin
               i_in     = '0;
               state_in = B_CORD;
            end
         end
         B_CORD: begin
            if (y_ff >= 0) begin
               x_in = x_ff + sy;
               y_in = y_ff - sx;
               z_in = z_ff + atan_q16(i_ff);
            end else begin
               x_in = x_ff - sy;
               y_in = y_ff + sx;
               z_in = z_ff - atan_q16(i_ff);
            end
            i_in = i_ff + 1'b1;
            if (i_ff == 5'(CORDIC_STEPS - 1)) begin
               state_in = B_HEAD;
            end
         end
         B_HEAD: begin
            if (zr > Z_W'(PI_Q13)) begin
               tgt_in = PI_Q13;
            end else if (zr < -Z_W'(PI_Q13)) begin
               tgt_in = -PI_Q13;
            end else begin
               tgt_in = ANG_W'(zr);
            end
            state_in = B_LIM;
         end
         B_LIM: begin
            state_in = B_FIN;
            if (d > PI_Q13) begin
               rate_in = -16'(maxr);
               if (d - TWO_PI_Q13 < -mc) begin
                  yaw_in = last - mc;
                  if (last - mc < -PI_Q13) yaw_in = last - mc + TWO_PI_Q13;
               end else begin
                  yaw_in = tgt_ff;
               end
            end else if (d < -PI_Q13) begin
               rate_in = 16'(maxr);
               if (d + TWO_PI_Q13 > mc) begin
                  yaw_in = last + mc;
                  if (last + mc > PI_Q13) yaw_in = last + mc - TWO_PI_Q13;
               end else begin
                  yaw_in = tgt_ff;
               end
            end else if (d < -mc) begin
               rate_in = -16'(maxr);
               yaw_in  = last - mc;
               if (last - mc < -PI_Q13) yaw_in = last - mc + TWO_PI_Q13;
            end else if (d > mc) begin
               rate_in = 16'(maxr);
               yaw_in  = last + mc;
               if (last + mc > PI_Q13) yaw_in = last + mc - TWO_PI_Q13;
            end else begin
               yaw_in    = tgt_ff;
               neg_in    = d[ANG_W-1];
               div_start = 1'b1;
               state_in  = B_DIV;
            end
         end
         B_DIV: begin
            if (div_done) begin
               if (neg_ff) begin
                  rate_in = (div_quo > 36'd32768) ? RATE_MIN : -16'(div_quo);
               end else begin
                  rate_in = (div_quo > 36'd32767) ? RATE_MAX : 16'(div_quo);
               end
               state_in = B_FIN;
            end
         end
         B_FIN: begin
            if (out_free) begin
               ov_in    = 1'b1;
               state_in = B_IDLE;
               case (cur_ff.kind)
                  KIND_TRACK: begin
                     logic signed [ANG_W-1:0] y_s;
                     logic signed [16:0]      r_s;
                     y_s = (ch <= mc) ? (last + yaw_ff) >>> 1 : yaw_ff;
                     r_s = (17'(last_rate_ff) + 17'(rate_ff)) >>> 1;
                     last_yaw_in  = 16'(y_s);
                     last_rate_in = 16'(r_s);
                     oy_in        = 16'(y_s);
                     or_in        = 16'(r_s);
                  end
                  KIND_HOLD: begin
                     oy_in = last_yaw_ff;
                     or_in = '0;
                  end
                  default: begin
                     last_yaw_in = '0;
                     oy_in       = '0;
                     or_in       = '0;
                  end
               endcase
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      i_ff    <= i_in;
      tgt_ff  <= tgt_in;
      yaw_ff  <= yaw_in;
      rate_ff <= rate_in;
      neg_ff  <= neg_in;
      oy_ff   <= oy_in;
      or_ff   <= or_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         last_yaw_ff  <= '0;
         last_rate_ff <= '0;
         ov_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_yaw_ff  <= last_yaw_in;
         last_rate_ff <= last_rate_in;
         ov_ff        <= ov_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_yaw    = oy_ff;
   assign rsp_rate   = or_ff;

endmodule

`default_nettype wire

// ===== sv/yaw_rate_limiter.sv =====
// ---------------------------------------------------------------------------
// Yaw rate limiter
// Heading rate limiter with wrap across plus or minus pi.
// ---------------------------------------------------------------------------
//  channel  direction  beat contents
//  req_     in         tuser: mode; tdata: dir_x, dir_y, elapsed_us
//  rsp_     out        tdata: yaw_out, yaw_rate_out
//  csr_     in         write enable, register index, write data
//
// The front end takes one tick at a time through three squaring steps, the step
// limit product, its reciprocal scaling and the push into the queue.
// The back end may take a tracked tick through normalising shifts, 17 CORDIC
// steps and a wait on the rate divider.
// Hold and invalid ticks go from the idle state straight to the final state.
// Reset is synchronous; it clears the stored yaw and rate and restores both
// registers to their defaults.
// The queue lets the front take a new tick while the back is busy or stalled.
`default_nettype none

module yaw_rate_limiter import yrl_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [87:0] req_tdata,   // dir_x, dir_y, elapsed_us, zero pad
   input  wire logic [1:0]  req_tuser,   // mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // yaw_out, yaw_rate_out
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);

   logic [14:0]    max_rate_ff;
   logic [30:0]    min_dist_ff;
   logic           q_push, q_pop;
   item_type       push_item, head_item;
   queue_stat_type q_stat;
   logic [15:0]    yaw, rate;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rate_ff <= MAX_RATE_RST;
         min_dist_ff <= MIN_DIST_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_RATE: max_rate_ff <= csr_wdata[14:0];
            CSR_MIN_DIST: min_dist_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   yrl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_mode       (req_tuser),
      .req_dir_x      (req_tdata[31:0]),
      .req_dir_y      (req_tdata[63:32]),
      .req_elapsed_us (req_tdata[83:64]),
      .max_rate       (max_rate_ff),
      .min_dist       (min_dist_ff),
      .q_full         (q_stat.full),
      .q_push         (q_push),
      .q_item         (push_item)
   );

   yrl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .stat      (q_stat)
   );

   yrl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .max_rate   (max_rate_ff),
      .q_item     (head_item),
      .q_empty    (q_stat.empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_yaw    (yaw),
      .rsp_rate   (rate)
   );

   assign rsp_tdata = {rate, yaw};

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full) else $error("push into a full queue");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty) else $error("pop from an empty queue");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && q_stat.empty) else $error("result after reset");

endmodule

`default_nettype wire

// ===== verif/yaw_rate_limiter_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Yaw rate limiter testbench
// Drives directed and random ticks through the limiter under several register
// settings and idle patterns. Each result beat is checked against its pinned
// value or a bit-exact predictor of heading, step limit, rate and smoothing.
// ---------------------------------------------------------------------------
`default_nettype none

module yaw_rate_limiter_test;
   import yrl_pkg::*;

   localparam logic [1:0] MODE_VOID  = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam longint     PI_FIX     = 25736;
   localparam longint     TWO_PI_FIX = 51472;
   localparam longint     PI_WIDE    = 205887;

   typedef struct {
      logic [1:0]  mode;
      logic [31:0] dir_x;
      logic [31:0] dir_y;
      logic [19:0] elapsed_us;
      bit          pinned;
      logic [15:0] yaw;
      logic [15:0] rate;
   } tick_row;

   typedef struct packed {
      logic [15:0] yaw;
      logic [15:0] rate;
   } heading_cmd;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;

   // Pinned expectation travelling alongside the request beat
   bit          pin_valid = 1'b0;
   heading_cmd  pin_value = '0;

   heading_cmd  cmd_queue[$];
   int          error_count = 0;
   int          result_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_request = 1'b0;
   int          hold_cycles = 0;

   // Predictor state and registers
   longint      rate_limit;
   longint      near_limit;
   longint      held_yaw;
   longint      held_rate;

   yaw_rate_limiter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // dir_x, dir_y, elapsed_us, zero pad
      .req_tuser  (req_tuser),    // mode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // yaw_out, yaw_rate_out
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   function automatic longint cordic_heading(longint x, longint y);
      longint z, ax, ay, dx, dy, r;
      z = 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_WIDE : -PI_WIDE;
         x = -x;
         y = -y;
      end
      ax = x;
      ay = (y < 0) ? -y : y;
      while (ax < (64'sd1 << 30) && ay < (64'sd1 << 30)) begin
         x = x * 2; y = y * 2; ax = ax * 2; ay = ay * 2;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x = x + dy; y = y - dx; z = z + longint'(atan_q16(5'(i)));
         end else begin
            x = x - dy; y = y + dx; z = z - longint'(atan_q16(5'(i)));
         end
      end
      r = (z + 4) >>> 3;
      if (r > PI_FIX) r = PI_FIX;
      if (r < -PI_FIX) r = -PI_FIX;
      return r;
   endfunction

   function automatic longint rounded_rate(longint change, longint el);
      longint num, mag, q;
      num = change * 1000000;
      mag = (num < 0) ? -num : num;
      q = (mag + el / 2) / el;
      if (num < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
   endfunction

   // Advances the stored yaw and rate by one tick and returns the command.
   function automatic heading_cmd predict_command(logic [1:0] mode, logic [31:0] raw_x,
                                                  logic [31:0] raw_y, logic [19:0] raw_el);
      longint dx, dy, el, target, d, mc, yaw, rate, ch;
      longint unsigned len2, md2;
      heading_cmd c;
      dx = longint'($signed(raw_x));
      dy = longint'($signed(raw_y));
      el = longint'(raw_el);
      if (mode == MODE_HOLD) begin
         c.yaw = 16'(held_yaw);
         c.rate = '0;
         return c;
      end
      if (mode != MODE_TRACK) begin
         held_yaw = 0;
         return '0;
      end
      if (el == 0) el = 1;
      len2 = longint'(dx * dx) + longint'(dy * dy);
      md2 = near_limit * near_limit;
      target = (len2 > md2) ? cordic_heading(dx, dy) : held_yaw;
      mc = (rate_limit * el + 500000) / 1000000;
      d = target - held_yaw;
      if (d > PI_FIX) begin
         yaw = (d - TWO_PI_FIX < -mc) ? held_yaw - mc : target;
         if (yaw < -PI_FIX) yaw += TWO_PI_FIX;
         rate = -rate_limit;
      end else if (d < -PI_FIX) begin
         yaw = (d + TWO_PI_FIX > mc) ? held_yaw + mc : target;
         if (yaw > PI_FIX) yaw -= TWO_PI_FIX;
         rate = rate_limit;
      end else if (d < -mc) begin
         yaw = held_yaw - mc;
         if (yaw < -PI_FIX) yaw += TWO_PI_FIX;
         rate = -rate_limit;
      end else if (d > mc) begin
         yaw = held_yaw + mc;
         if (yaw > PI_FIX) yaw -= TWO_PI_FIX;
         rate = rate_limit;
      end else begin
         yaw = target;
         rate = rounded_rate(d, el);
      end
      ch = yaw - held_yaw;
      if (ch < 0) ch = -ch;
      if (ch <= mc) yaw = (held_yaw + yaw) >>> 1;
      rate = (held_rate + rate) >>> 1;
      held_yaw = yaw;
      held_rate = rate;
      c.yaw = 16'(yaw);
      c.rate = 16'(rate);
      return c;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t: result %0d %s mismatch: got %0d expected %0d", $realtime,
               result_count, what, $signed(got), $signed(want));
      error_count++;
   endtask

   // Both handshakes are sampled here, so queue order follows beat order.
   always @(posedge clock) begin
      heading_cmd predicted, want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted = predict_command(req_tuser, req_tdata[31:0], req_tdata[63:32],
                                        req_tdata[83:64]);
            cmd_queue.push_back(pin_valid ? pin_value : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count++;
            if (cmd_queue.size() == 0) begin
               $display("%0t: result beat with nothing outstanding", $realtime);
               error_count++;
            end else begin
               want = cmd_queue.pop_front();
               if (rsp_tdata[15:0] !== want.yaw)
                  report_mismatch("yaw", rsp_tdata[15:0], want.yaw);
               if (rsp_tdata[31:16] !== want.rate)
                  report_mismatch("rate", rsp_tdata[31:16], want.rate);
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request <= 1'b0;
         hold_cycles = 600;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Leaves the write enable high; the caller lowers it after the last write.
   task automatic write_register(logic [0:0] index, logic [30:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == CSR_MAX_RATE)
         rate_limit = longint'(value[14:0]);
      else
         near_limit = longint'(value);
   endtask

   // Called just after a rising edge; leaves the beat accepted.
   task automatic send_tick(tick_row row);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= row.mode;
      req_tdata <= {4'b0, row.elapsed_us, row.dir_y, row.dir_x};
      pin_valid <= row.pinned;
      pin_value <= {row.yaw, row.rate};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (cmd_queue.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic logic [31:0] random_component();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return 32'($signed($urandom) >>> $urandom_range(31, 8));
         2:       return 32'($signed($urandom) >>> $urandom_range(31, 16));
         default: return 32'($signed($urandom) >>> $urandom_range(31));
      endcase
   endfunction

   function automatic tick_row random_tick();
      tick_row row;
      int pick;
      pick = $urandom_range(99);
      row.mode = (pick < 80) ? MODE_TRACK : (pick < 88) ? MODE_HOLD :
                 (pick < 96) ? MODE_VOID : MODE_SPARE;
      row.dir_x = random_component();
      row.dir_y = random_component();
      pick = $urandom_range(9);
      row.elapsed_us = (pick < 6) ? 20'($urandom_range(12000, 8000)) :
                       (pick < 9) ? 20'($urandom_range(1000000)) : 20'($urandom);
      row.pinned = 1'b0;
      row.yaw = '0;
      row.rate = '0;
      return row;
   endfunction

   tick_row directed_rows[] = '{
      '{MODE_HOLD,  32'h0000_0000, 32'h0000_0000, 20'd10000,   1'b1, 16'd0, 16'd0},
      '{MODE_VOID,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd10000,   1'b1, 16'd0, 16'd0},
      '{MODE_SPARE, 32'h8000_0000, 32'h8000_0000, 20'hFFFFF,   1'b1, 16'd0, 16'd0},
      // A zero vector keeps the reset heading, even with no elapsed time.
      '{MODE_TRACK, 32'h0000_0000, 32'h0000_0000, 20'd0,       1'b1, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h7FFF_FFFF, 32'h0000_0000, 20'd1000000, 1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h8000_0000, 32'h0000_0000, 20'd1000000, 1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h8000_0000, 32'hFFFF_FFFF, 20'd10000,   1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h8000_0000, 32'h0000_0001, 20'd10000,   1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'hFFFF_FFFF, 32'h8000_0000, 20'hFFFFF,   1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h8000_0000, 32'h8000_0000, 20'd1,       1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd500000,  1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h0000_0001, 32'h0000_0001, 20'd10000,   1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h0000_199A, 32'h0000_0000, 20'd10000,   1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'hFFFF_0000, 32'h0000_0100, 20'd10000,   1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'hFFFF_0000, 32'hFFFF_FF00, 20'd10000,   1'b0, 16'd0, 16'd0},
      '{MODE_HOLD,  32'h1234_5678, 32'h8765_4321, 20'd10000,   1'b0, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h0001_0000, 32'h0001_0000, 20'd10000,   1'b0, 16'd0, 16'd0},
      '{MODE_VOID,  32'h0000_0000, 32'h0000_0000, 20'd10000,   1'b1, 16'd0, 16'd0},
      '{MODE_TRACK, 32'h0000_0000, 32'h0001_0000, 20'd0,       1'b0, 16'd0, 16'd0}
   };

   initial begin
      tick_row row;
      logic [30:0] phase_rate, phase_dist;
      rate_limit = longint'(MAX_RATE_RST);
      near_limit = longint'(MIN_DIST_RST);
      held_yaw = 0;
      held_rate = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_tick(directed_rows[i]);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       begin phase_rate = 31'd0;     phase_dist = 31'd0;          end
            1:       begin phase_rate = 31'd32767; phase_dist = 31'h7FFF_FFFF;  end
            2:       begin phase_rate = 31'd25736; phase_dist = 31'd6554;       end
            default: begin
               phase_rate = 31'($urandom_range(32767));
               phase_dist = 31'($urandom_range(200000));
            end
         endcase
         write_register(CSR_MAX_RATE, phase_rate);
         write_register(CSR_MIN_DIST, phase_dist);
         csr_we <= 1'b0;
         send_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 58 : 0;
         recv_idle_pct = (phase < 2) ? 58 : (phase < 4) ? 36 : 0;
         @(posedge clock);
         for (int n = 0; n < 225; n++) begin
            if (phase == 4 && n == 40) hold_request <= 1'b1;
            row = random_tick();
            send_tick(row);
         end
         drain();
      end

      $display("Covered %0d result beats over six register settings,", result_count);
      $display("directed extremes, wrap cases, hold, invalid and a long output stall.");
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
